/* rtl/core/qsph_pkg.sv */
// Shared constants, types and base decode for the quartet site-pattern histogram.
// No dependencies.
package qsph_pkg;

    localparam int MAX_COLUMNS_LOG2 = 20;
    localparam int FRACTION_BITS    = 16;

    localparam int CNT_W  = MAX_COLUMNS_LOG2 + 1;   // bins and column count
    localparam int Q_W    = FRACTION_BITS + 1;      // quotient, 1.0 included
    localparam int REM_W  = CNT_W + 1;              // remainder after shift
    localparam int STEP_W = $clog2(Q_W);
    localparam int PAT_W  = 6;
    localparam int N_PAT  = 1 << PAT_W;

    localparam logic [CNT_W-1:0]  BIN_CAP   = {1'b1, {MAX_COLUMNS_LOG2{1'b0}}};
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);
    localparam logic [PAT_W-1:0]  PAT_LAST  = PAT_W'(N_PAT - 1);

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_C = 8'h43;

    typedef struct packed {
        logic ok;
        logic [1:0] code;
    } t_base;

    // divider request group
    typedef struct packed {
        logic start;
        logic ack;
    } t_div_req;

    function automatic t_base base_code(input logic [7:0] ch);
        t_base b;
        b.ok   = 1'b1;
        b.code = 2'd0;
        case (ch)
            CHAR_A:  b.code = 2'd0;
            CHAR_T:  b.code = 2'd1;
            CHAR_G:  b.code = 2'd2;
            CHAR_C:  b.code = 2'd3;
            default: b.ok   = 1'b0;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/qsph_cell.sv */
// One histogram bin of the cell chain: counts hits on its own pattern and,
// during readout, takes the bin of its upper neighbor. Uses qsph_pkg.
module qsph_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [qsph_pkg::PAT_W-1:0]    i_idx,
    input  logic                          i_inc,
    input  logic [qsph_pkg::PAT_W-1:0]    i_pattern,
    input  logic                          i_shift,
    input  logic [qsph_pkg::CNT_W-1:0]    i_next_bin,
    output logic [qsph_pkg::CNT_W-1:0]    o_bin
);

    logic [qsph_pkg::CNT_W-1:0] r_bin;
    logic [qsph_pkg::CNT_W-1:0] n_bin;

    always_comb begin
        n_bin = r_bin;
        if (i_shift) begin
            n_bin = i_next_bin;
        end else if (i_inc && i_pattern == i_idx && r_bin != qsph_pkg::BIN_CAP) begin
            n_bin = r_bin + qsph_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
        end else begin
            r_bin <= n_bin;
        end
    end

    assign o_bin = r_bin;

endmodule

/* rtl/core/qsph_div.sv */
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRACTION_BITS / den)
// for num <= den. Uses qsph_pkg.
module qsph_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qsph_pkg::t_div_req            i_req,
    input  logic [qsph_pkg::CNT_W-1:0]    i_num,
    input  logic [qsph_pkg::CNT_W-1:0]    i_den,
    output logic                          o_done,
    output logic [qsph_pkg::Q_W-1:0]      o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [qsph_pkg::STEP_W-1:0]   r_step;
    logic [qsph_pkg::REM_W-1:0]    r_rem;
    logic [qsph_pkg::CNT_W-1:0]    r_den;
    logic [qsph_pkg::Q_W-1:0]      r_quot;

    logic [qsph_pkg::REM_W-1:0]    w_rem_in;
    logic [qsph_pkg::REM_W-1:0]    w_den_ext;
    logic                          w_ge;

    // first step tests num >= den without a shift (gives the 1.0 bit)
    assign w_den_ext = {1'b0, r_den};
    assign w_rem_in  = (r_step == '0) ? r_rem : {r_rem[qsph_pkg::REM_W-2:0], 1'b0};
    assign w_ge      = (w_rem_in >= w_den_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_req.ack) begin
                r_done <= 1'b0;
            end
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + qsph_pkg::STEP_W'(1);
                if (r_step == qsph_pkg::STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_rem_in - w_den_ext) : w_rem_in;
            r_quot <= {r_quot[qsph_pkg::Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done)) else $error("divider busy and done together");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start && r_step == qsph_pkg::STEP_LAST) |=> r_done)
        else $error("divider did not finish after last step");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= qsph_pkg::STEP_LAST))
        else $error("divider step out of range");

endmodule

/* rtl/core/quartet_site_pattern_histogram.sv */
// Top level of the quartet site-pattern histogram: column decode, chain of 64
// bin cells, divider and readout control. Uses qsph_pkg, qsph_cell, qsph_div.
//
// Input stream: one alignment column per request, four character bytes in
// tdata (first sequence lowest), tlast marks the final column. Characters
// other than A, T, G, C make the column skipped (it still ends the run).
// While collecting, a column is taken every cycle; its bin and the valid
// column count update at the accepting edge (both saturate at 2^20).
// On the last column the block enters readout and holds tready low. The
// cell chain shifts toward cell 0, one bin per result, zeros entering at
// the top, so the histogram is clear when readout ends. For each result
// the divider is started on the bin in cell 0 and divides it by the column
// count; when done and the output register is free the result loads, and
// only then does the next division start. Results leave through one output register:
// a stalled receiver holds that register and the chain waits with it.
// tready rises again at the edge that loads the final result.
// Reset clears the bins, the count and the handshake state; the block is
// ready to collect on the first cycle after reset.
module quartet_site_pattern_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // char_first, char_second, char_third, char_fourth
    input  logic        i_s_axis_tlast,   // last_column
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // pattern, frequency, valid_columns, zero fill
    output logic        o_m_axis_tuser,   // no_valid_columns
    output logic        o_m_axis_tlast    // last_pattern
);

    typedef enum logic {
        S_COLLECT,
        S_EMIT
    } t_state;

    t_state r_state;
    logic [qsph_pkg::CNT_W-1:0] r_count;
    logic [qsph_pkg::PAT_W-1:0] r_idx;
    logic                       r_div_start;
    logic                       r_m_valid;
    logic [qsph_pkg::PAT_W-1:0] r_m_pattern;
    logic [qsph_pkg::Q_W-1:0]   r_m_freq;
    logic [qsph_pkg::CNT_W-1:0] r_m_count;
    logic                       r_m_empty;
    logic                       r_m_last;

    qsph_pkg::t_base b1, b2, b3, b4;
    logic                       w_accept;
    logic                       w_col_ok;
    logic                       w_inc;
    logic [qsph_pkg::PAT_W-1:0] w_pattern;
    logic                       w_load;
    logic                       w_div_done;
    logic [qsph_pkg::Q_W-1:0]   w_quot;
    qsph_pkg::t_div_req         w_div_req;
    logic [qsph_pkg::CNT_W-1:0] w_bin [qsph_pkg::N_PAT];
    logic [qsph_pkg::CNT_W-1:0] w_next [qsph_pkg::N_PAT];

    assign b1 = qsph_pkg::base_code(i_s_axis_tdata[7:0]);
    assign b2 = qsph_pkg::base_code(i_s_axis_tdata[15:8]);
    assign b3 = qsph_pkg::base_code(i_s_axis_tdata[23:16]);
    assign b4 = qsph_pkg::base_code(i_s_axis_tdata[31:24]);

    assign o_s_axis_tready = (r_state == S_COLLECT);
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_col_ok  = b1.ok && b2.ok && b3.ok && b4.ok;
    assign w_inc     = w_accept && w_col_ok;
    assign w_pattern = {b2.code ^ b1.code, b3.code ^ b1.code, b4.code ^ b1.code};

    // next result goes out when the divider is done and the output slot frees
    assign w_load = (r_state == S_EMIT) && w_div_done && (!r_m_valid || i_m_axis_tready);

    genvar g;
    generate
        for (g = 0; g < qsph_pkg::N_PAT; g++) begin : g_cell
            if (g == qsph_pkg::N_PAT - 1) begin : g_top
                assign w_next[g] = '0;
            end else begin : g_mid
                assign w_next[g] = w_bin[g+1];
            end
            qsph_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_idx      (qsph_pkg::PAT_W'(g)),
                .i_inc      (w_inc),
                .i_pattern  (w_pattern),
                .i_shift    (w_load),
                .i_next_bin (w_next[g]),
                .o_bin      (w_bin[g])
            );
        end
    endgenerate

    assign w_div_req.start = r_div_start;
    assign w_div_req.ack   = w_load;

    qsph_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_num   (w_bin[0]),
        .i_den   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_count     <= '0;
            r_idx       <= '0;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_COLLECT: begin
                    if (w_inc && r_count != qsph_pkg::BIN_CAP) begin
                        r_count <= r_count + qsph_pkg::CNT_W'(1);
                    end
                    if (w_accept && i_s_axis_tlast) begin
                        r_state     <= S_EMIT;
                        r_idx       <= '0;
                        r_div_start <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_m_valid <= 1'b1;
                        r_idx     <= r_idx + qsph_pkg::PAT_W'(1);
                        if (r_idx == qsph_pkg::PAT_LAST) begin
                            r_state <= S_COLLECT;
                            r_count <= '0;
                        end else begin
                            r_div_start <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_pattern <= r_idx;
            r_m_freq    <= (r_count == '0) ? '0 : w_quot;
            r_m_count   <= r_count;
            r_m_empty   <= (r_count == '0);
            r_m_last    <= (r_idx == qsph_pkg::PAT_LAST);
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'b0000, r_m_count, r_m_freq, r_m_pattern};
    assign o_m_axis_tuser  = r_m_empty;
    assign o_m_axis_tlast  = r_m_last;

    a_bin_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLLECT) |-> (w_bin[0] <= r_count))
        else $error("bin exceeds column count");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_idx == qsph_pkg::PAT_LAST)
        |=> (r_count == '0 && w_bin[0] == '0 && w_bin[qsph_pkg::N_PAT-1] == '0))
        else $error("histogram not clear after readout");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_idx == qsph_pkg::PAT_LAST) |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("final result without tlast");

    a_freq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_m_freq <= {1'b1, {qsph_pkg::FRACTION_BITS{1'b0}}}))
        else $error("frequency above 1.0");

endmodule
